@@ design/estws_pkg.sv @@
// Shared types and constants of the event slot table with wake selection.
package estws_pkg;

   // Field widths of the request, response and register port.
   localparam int REQ_TYPE_W  = 3;
   localparam int EVENT_W     = 16;
   localparam int CALLER_W    = 32;
   localparam int SLOT_IDX_W  = 4;
   localparam int SIGNAL_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD       = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_OWNED_ADD = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE    = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR     = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_WAIT      = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] RSP_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_DENIED = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_NONE   = 2'd3;

   // Wake policies.
   localparam logic [1:0] POL_LOWEST  = 2'd0;
   localparam logic [1:0] POL_HIGHEST = 2'd1;
   localparam logic [1:0] POL_RR      = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_WAKE_POLICY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWNER_ID     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWNERSHIP_ON = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REPLY
   } estws_state_type;

   typedef struct packed {
      logic                capture;
      logic                append;
      logic                clear;
      logic                shift_load;
      logic                shift_read;
      logic                shift_write;
      logic                remove_done;
      logic                select;
      logic                set_code;
      logic [STATUS_W-1:0] code;
      logic                load_rsp;
   } estws_cmd_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  add_bad;
      logic                  owner_bad;
      logic                  remove_bad;
      logic                  shift_more;
      logic                  found;
   } estws_sts_type;

endpackage

@@ design/estws_if.sv @@
// Request and response channel interfaces of the event slot table.
interface estws_req_if import estws_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [EVENT_W-1:0]    event_id;
   logic [CALLER_W-1:0]   caller_id;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic [SIGNAL_W-1:0]   signaled_bits;

   modport source (output valid, req_type, event_id, caller_id, slot_index, signaled_bits,
                   input ready);
   modport sink (input valid, req_type, event_id, caller_id, slot_index, signaled_bits,
                 output ready);
endinterface

interface estws_rsp_if import estws_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SLOT_IDX_W-1:0]  chosen_slot;
   logic [EVENT_W-1:0]     chosen_event;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, status, chosen_slot, chosen_event, entry_count,
                   input ready);
   modport sink (input valid, status, chosen_slot, chosen_event, entry_count,
                 output ready);
endinterface

@@ design/estws_ctrl.sv @@
// Controller state machine of the event slot table.
module estws_ctrl import estws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  estws_sts_type sts,
   output estws_cmd_type cmd
);

   estws_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.req_type == REQ_REMOVE && !sts.remove_bad) state_in = S_SHIFT_RD;
            else state_in = S_REPLY;
         end
         S_SHIFT_RD: begin
            state_in = sts.shift_more ? S_SHIFT_WR : S_REPLY;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_REPLY: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.set_code = 1'b1;
            cmd.code     = RSP_OK;
            case (sts.req_type)
               REQ_ADD: begin
                  if (sts.add_bad) cmd.code = RSP_REJECT;
                  else cmd.append = 1'b1;
               end
               REQ_OWNED_ADD: begin
                  if (sts.add_bad) cmd.code = RSP_REJECT;
                  else if (sts.owner_bad) cmd.code = RSP_DENIED;
                  else cmd.append = 1'b1;
               end
               REQ_REMOVE: begin
                  if (sts.remove_bad) cmd.code = RSP_REJECT;
                  else cmd.shift_load = 1'b1;
               end
               REQ_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               REQ_WAIT: begin
                  cmd.select = 1'b1;
                  cmd.code   = sts.found ? RSP_OK : RSP_NONE;
               end
               default: begin
                  cmd.code = RSP_REJECT;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (sts.shift_more) cmd.shift_read = 1'b1;
            else cmd.remove_done = 1'b1;
         end
         S_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
         end
         S_REPLY: begin
            cmd.load_rsp = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Only one request is in the block at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && state_ff == S_DECODE)
      else $error("request accepted while another was in progress");

   // A finished reply always reaches the output register.
   a_reply_lands: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REPLY && out_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("reply was not loaded into the output register");

endmodule

@@ design/estws_dpath.sv @@
// Datapath of the event slot table: slot memory, count, cursor and wake selection.
module estws_dpath import estws_pkg::*; #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [EVENT_W-1:0]     event_id,
   input  logic [CALLER_W-1:0]    caller_id,
   input  logic [SLOT_IDX_W-1:0]  slot_index,
   input  logic [SIGNAL_W-1:0]    signaled_bits,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  estws_cmd_type          cmd,
   output estws_sts_type          sts,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_IDX_W-1:0]  rsp_chosen_slot,
   output logic [EVENT_W-1:0]     rsp_chosen_event,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   localparam int AW   = $clog2(SLOTS);
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int SW   = (SLOTS < SIGNAL_W) ? SLOTS : SIGNAL_W;
   localparam int CMPW = (CW > SLOT_IDX_W) ? CW : SLOT_IDX_W;

   // Captured request.
   logic [REQ_TYPE_W-1:0] req_type_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [CALLER_W-1:0]   caller_ff;
   logic [SLOT_IDX_W-1:0] index_ff;
   logic [SW-1:0]         bits_ff;
   logic [ID_BITS-1:0]    id_masked;

   // Configuration.
   logic [1:0]          policy_ff;
   logic [CALLER_W-1:0] owner_ff;
   logic                own_on_ff;

   // Table state.
   logic [ID_BITS-1:0] mem [SLOTS];
   logic [ID_BITS-1:0] rd_data_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      rr_ff, rr_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [CW-1:0]      cursor_plus1;

   // Result bookkeeping.
   logic [STATUS_W-1:0] code_ff;
   logic                sel_ok_ff;
   logic [AW-1:0]       pick_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [SLOT_IDX_W-1:0]  slot_out_ff;
   logic [EVENT_W-1:0]     event_out_ff;
   logic [COUNT_OUT_W-1:0] count_out_ff;
   logic [EVENT_W-1:0]     rd_event;
   logic [COUNT_OUT_W-1:0] count_out;
   logic [SLOT_IDX_W-1:0]  pick_out;

   // Selection.
   logic [SW-1:0] cand;
   logic          lo_found, rr_found, found;
   logic [AW-1:0] lo_pick, hi_pick, rr_pick, pick;

   // Memory port signals.
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ID_BITS-1:0] wr_data;

   if (ID_BITS >= EVENT_W) begin : g_id_wide
      assign id_masked = ID_BITS'(event_id);
      assign rd_event  = rd_data_ff[EVENT_W-1:0];
   end else begin : g_id_narrow
      assign id_masked = event_id[ID_BITS-1:0];
      assign rd_event  = EVENT_W'(rd_data_ff);
   end

   if (CW >= COUNT_OUT_W) begin : g_cnt_wide
      assign count_out = count_ff[COUNT_OUT_W-1:0];
   end else begin : g_cnt_narrow
      assign count_out = COUNT_OUT_W'(count_ff);
   end

   if (AW >= SLOT_IDX_W) begin : g_pick_wide
      assign pick_out = pick_ff[SLOT_IDX_W-1:0];
   end else begin : g_pick_narrow
      assign pick_out = SLOT_IDX_W'(pick_ff);
   end

   assign cursor_plus1 = cursor_ff + CW'(1);

   // Signaled slots that are inside the table.
   always_comb begin
      for (int i = 0; i < SW; i++) begin
         cand[i] = bits_ff[i] && (CW'(i) < count_ff);
      end
   end

   always_comb begin
      lo_found = 1'b0;
      lo_pick  = '0;
      hi_pick  = '0;
      rr_found = 1'b0;
      rr_pick  = '0;
      for (int i = SW - 1; i >= 0; i--) begin
         if (cand[i]) begin
            lo_found = 1'b1;
            lo_pick  = AW'(i);
         end
      end
      for (int i = 0; i < SW; i++) begin
         if (cand[i]) begin
            hi_pick  = AW'(i);
         end
      end
      // Round robin: first signaled slot at or after the cursor, else wrap to the lowest.
      for (int i = SW - 1; i >= 0; i--) begin
         if (cand[i] && AW'(i) >= rr_ff) begin
            rr_found = 1'b1;
            rr_pick  = AW'(i);
         end
      end
   end

   always_comb begin
      case (policy_ff)
         POL_LOWEST:  pick = lo_pick;
         POL_HIGHEST: pick = hi_pick;
         POL_RR:      pick = rr_found ? rr_pick : lo_pick;
         default:     pick = lo_pick;
      endcase
   end

   assign found = lo_found;

   assign sts.req_type   = req_type_ff;
   assign sts.add_bad    = (id_ff == '0) || (count_ff == CW'(SLOTS)) ||
                           (req_type_ff == REQ_OWNED_ADD && caller_ff == '0);
   assign sts.owner_bad  = own_on_ff && (owner_ff != caller_ff);
   assign sts.remove_bad = CMPW'(index_ff) >= CMPW'(count_ff);
   assign sts.shift_more = cursor_plus1 < count_ff;
   assign sts.found      = found;

   // Next values of count, round-robin pointer and removal cursor.
   always_comb begin
      count_in  = count_ff;
      rr_in     = rr_ff;
      cursor_in = cursor_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
         if (CW'(rr_ff) >= count_in) rr_in = '0;
      end
      if (cmd.clear) begin
         count_in = '0;
         rr_in    = '0;
      end
      if (cmd.remove_done) begin
         // The cursor was below the old count, so it can only land on the new count.
         count_in = count_ff - CW'(1);
         if (CW'(rr_ff) >= count_in) rr_in = '0;
      end
      if (cmd.select && found && policy_ff == POL_RR) begin
         rr_in = (CW'(pick) + CW'(1) == count_ff) ? '0 : pick + AW'(1);
      end
      if (cmd.shift_load) cursor_in = CW'(index_ff);
      if (cmd.shift_write) cursor_in = cursor_plus1;
   end

   assign wr_en   = cmd.append || cmd.shift_write;
   assign wr_addr = cmd.append ? count_ff[AW-1:0] : cursor_ff[AW-1:0];
   assign wr_data = cmd.append ? id_ff : rd_data_ff;
   assign rd_en   = cmd.select || cmd.shift_read;
   assign rd_addr = cmd.select ? pick : cursor_plus1[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rr_ff     <= '0;
         policy_ff <= POL_LOWEST;
         owner_ff  <= '0;
         own_on_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rr_ff    <= rr_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WAKE_POLICY:  policy_ff <= csr_wdata[1:0];
               CSR_OWNER_ID:     owner_ff  <= csr_wdata;
               CSR_OWNERSHIP_ON: own_on_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (cmd.capture) begin
         req_type_ff <= req_type;
         id_ff       <= id_masked;
         caller_ff   <= caller_id;
         index_ff    <= slot_index;
         bits_ff     <= signaled_bits[SW-1:0];
      end
      if (cmd.set_code) begin
         code_ff   <= cmd.code;
         sel_ok_ff <= cmd.select && found;
         pick_ff   <= pick;
      end
      if (cmd.load_rsp) begin
         status_ff    <= code_ff;
         slot_out_ff  <= sel_ok_ff ? pick_out : '0;
         event_out_ff <= sel_ok_ff ? rd_event : '0;
         count_out_ff <= count_out;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_chosen_slot  = slot_out_ff;
   assign rsp_chosen_event = event_out_ff;
   assign rsp_entry_count  = count_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("slot count beyond table size");

   a_cursor_in_table: assert property (@(posedge clock) disable iff (reset)
      (CW'(rr_ff) < count_ff) || (count_ff == '0 && rr_ff == '0))
      else $error("round-robin cursor outside the occupied slots");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove_done |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not drop the count by one");

endmodule

@@ design/event_slot_table_wake_select_top.sv @@
// Top level of the event slot table with wake selection.
//
//  channel   direction  transaction
//  req_ch    in         one request: type, event id, caller id, slot index, signal bits
//  rsp_ch    out        one response per request: status, chosen slot and event, count
//  csr_*     in         register write, one per cycle while write enable is high
//
// Add, owned add, clear, wait and rejected requests pass through decode and reply
// before the next acceptance. A remove walks the later slots through the single slot
// memory, with a read state and then a write state for each slot moved.
// A new request is taken while an earlier response still waits in the output register.
// Reset empties the table at once; slots past the count are never read, so no
// clearing pass is needed.
module event_slot_table_wake_select_top import estws_pkg::*; #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   estws_req_if.sink              req_ch,
   estws_rsp_if.source            rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   estws_cmd_type cmd;
   estws_sts_type sts;

   estws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   estws_dpath #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_ch.req_type),
      .event_id         (req_ch.event_id),
      .caller_id        (req_ch.caller_id),
      .slot_index       (req_ch.slot_index),
      .signaled_bits    (req_ch.signaled_bits),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_status       (rsp_ch.status),
      .rsp_chosen_slot  (rsp_ch.chosen_slot),
      .rsp_chosen_event (rsp_ch.chosen_event),
      .rsp_entry_count  (rsp_ch.entry_count)
   );

endmodule

@@ tb/event_slot_table_wake_select_top_tb.sv @@
// Self-checking testbench for the event slot table with wake selection.
module event_slot_table_wake_select_top_tb import estws_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 40;
   localparam int SEGMENTS    = 8;
   localparam int SEGMENT_LEN = 55;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SLOT_IDX_W-1:0]  slot;
      logic [EVENT_W-1:0]     event_id;
      logic [COUNT_OUT_W-1:0] count;
   } wake_reply_type;

   // Tracks the slot table, the cursor and the registers, and predicts one reply per
   // accepted request transaction.
   class slot_table_tracker;
      logic [EVENT_W-1:0]  ids[SLOTS];
      int unsigned         count;
      int unsigned         cursor;
      logic [1:0]          policy;
      logic [CALLER_W-1:0] owner;
      bit                  owner_check;
      wake_reply_type      replies_due[$];
      int                  errors;

      function new();
         foreach (ids[i]) ids[i] = '0;
         count       = 0;
         cursor      = 0;
         policy      = POL_LOWEST;
         owner       = '0;
         owner_check = 1'b0;
         errors      = 0;
      endfunction

      function void set_registers(logic [1:0] pol, logic [CALLER_W-1:0] own, bit chk);
         policy      = pol;
         owner       = own;
         owner_check = chk;
      endfunction

      function void take_request(logic [REQ_TYPE_W-1:0] kind, logic [EVENT_W-1:0] ev,
                                 logic [CALLER_W-1:0] caller, logic [SLOT_IDX_W-1:0] idx,
                                 logic [SIGNAL_W-1:0] bits);
         wake_reply_type r;
         bit             found;
         int             pick;
         int             n;
         int             j;
         r     = '0;
         found = 1'b0;
         pick  = 0;
         n     = count;
         case (kind)
            REQ_ADD, REQ_OWNED_ADD: begin
               if (ev == '0 || count >= SLOTS || (kind == REQ_OWNED_ADD && caller == '0)) begin
                  r.status = RSP_REJECT;
               end else if (kind == REQ_OWNED_ADD && owner_check && caller != owner) begin
                  r.status = RSP_DENIED;
               end else begin
                  ids[count] = ev;
                  count++;
                  if (cursor >= count) cursor = 0;
               end
            end
            REQ_REMOVE: begin
               if (idx >= count) begin
                  r.status = RSP_REJECT;
               end else begin
                  for (int i = idx; i + 1 < n; i++) ids[i] = ids[i + 1];
                  ids[count - 1] = '0;
                  count--;
                  if (count == 0) cursor = 0;
                  else if (cursor >= count) cursor = cursor % count;
               end
            end
            REQ_CLEAR: begin
               foreach (ids[i]) ids[i] = '0;
               count  = 0;
               cursor = 0;
            end
            REQ_WAIT: begin
               if (policy == POL_HIGHEST) begin
                  for (int i = n - 1; i >= 0; i--) begin
                     if (!found && bits[i]) begin
                        found = 1'b1;
                        pick  = i;
                     end
                  end
               end else if (policy == POL_RR) begin
                  for (int i = 0; i < n; i++) begin
                     j = (cursor + i) % n;
                     if (!found && bits[j]) begin
                        found = 1'b1;
                        pick  = j;
                     end
                  end
                  if (found) cursor = (pick + 1) % n;
               end else begin
                  // The unused policy code falls back to lowest slot first.
                  for (int i = 0; i < n; i++) begin
                     if (!found && bits[i]) begin
                        found = 1'b1;
                        pick  = i;
                     end
                  end
               end
               if (found) begin
                  r.slot     = SLOT_IDX_W'(pick);
                  r.event_id = ids[pick];
               end else begin
                  r.status = RSP_NONE;
               end
            end
            default: r.status = RSP_REJECT;
         endcase
         r.count = COUNT_OUT_W'(count);
         replies_due.push_back(r);
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      function void match_reply(wake_reply_type got);
         wake_reply_type want;
         if (replies_due.size() == 0) begin
            flag($sformatf("unexpected reply status %0d slot %0d event %h count %0d",
                           got.status, got.slot, got.event_id, got.count));
         end else begin
            want = replies_due.pop_front();
            if (got !== want)
               flag($sformatf({"reply mismatch: expected status %0d slot %0d event %h ",
                               "count %0d, got status %0d slot %0d event %h count %0d"},
                              want.status, want.slot, want.event_id, want.count,
                              got.status, got.slot, got.event_id, got.count));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   estws_req_if req_ch ();
   estws_rsp_if rsp_ch ();

   event_slot_table_wake_select_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   slot_table_tracker tracker = new();
   int sender_idle_pct = 0;
   int reply_stall_pct = 0;
   int quiet_cycles    = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(0, 99) >= reply_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.match_reply('{rsp_ch.status, rsp_ch.chosen_slot, rsp_ch.chosen_event,
                               rsp_ch.entry_count});
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL event_slot_table_wake_select_top");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic [REQ_TYPE_W-1:0] kind, logic [EVENT_W-1:0] ev,
                               logic [CALLER_W-1:0] caller, logic [SLOT_IDX_W-1:0] idx,
                               logic [SIGNAL_W-1:0] bits);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.req_type      = kind;
      req_ch.event_id      = ev;
      req_ch.caller_id     = caller;
      req_ch.slot_index    = idx;
      req_ch.signaled_bits = bits;
      req_ch.valid         = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      tracker.take_request(kind, ev, caller, idx, bits);
      @(negedge clock);
   endtask

   task automatic write_registers(logic [1:0] pol, logic [CALLER_W-1:0] own, bit chk);
      csr_we    = 1'b1;
      csr_index = CSR_WAKE_POLICY;
      csr_wdata = CSR_DATA_W'(pol);
      @(negedge clock);
      csr_index = CSR_OWNER_ID;
      csr_wdata = own;
      @(negedge clock);
      csr_index = CSR_OWNERSHIP_ON;
      csr_wdata = CSR_DATA_W'(chk);
      @(negedge clock);
      csr_we = 1'b0;
      tracker.set_registers(pol, own, chk);
   endtask

   task automatic wait_for_replies();
      req_ch.valid = 1'b0;
      while (tracker.replies_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Weighted toward adds while the table has room so that it fills regularly.
   task automatic random_request();
      logic [REQ_TYPE_W-1:0] kind;
      logic [EVENT_W-1:0]    ev;
      logic [CALLER_W-1:0]   caller;
      logic [SLOT_IDX_W-1:0] idx;
      logic [SIGNAL_W-1:0]   bits;
      int                    roll;
      int                    add_share;
      add_share = (tracker.count < 12) ? 45 : 22;
      roll = $urandom_range(0, 99);
      if (roll < add_share * 3 / 5)   kind = REQ_ADD;
      else if (roll < add_share)      kind = REQ_OWNED_ADD;
      else if (roll < add_share + 18) kind = REQ_REMOVE;
      else if (roll < add_share + 21) kind = REQ_CLEAR;
      else if (roll < 96)             kind = REQ_WAIT;
      else                            kind = REQ_TYPE_W'($urandom_range(5, 7));

      roll = $urandom_range(0, 99);
      if (roll < 5)       ev = '0;
      else if (roll < 10) ev = '1;
      else                ev = EVENT_W'($urandom_range(1, 65535));

      roll = $urandom_range(0, 99);
      if (roll < 50)      caller = tracker.owner;
      else if (roll < 60) caller = '0;
      else if (roll < 65) caller = '1;
      else                caller = $urandom;

      if (tracker.count > 0 && $urandom_range(0, 99) < 85)
         idx = SLOT_IDX_W'($urandom_range(0, tracker.count - 1));
      else
         idx = SLOT_IDX_W'($urandom_range(0, 15));

      case ($urandom_range(0, 5))
         0, 5:    bits = SIGNAL_W'($urandom);
         1:       bits = SIGNAL_W'($urandom & $urandom & $urandom);
         2:       bits = SIGNAL_W'(1) << $urandom_range(0, SIGNAL_W - 1);
         3:       bits = '0;
         default: bits = '1;
      endcase
      send_request(kind, ev, caller, idx, bits);
   endtask

   initial begin
      logic [CALLER_W-1:0] owner_pick;
      int                  phase;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_WAKE_POLICY;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = REQ_ADD;
      req_ch.event_id      = '0;
      req_ch.caller_id     = '0;
      req_ch.slot_index    = '0;
      req_ch.signaled_bits = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table, rejected ids and callers, unknown codes.
      send_request(REQ_WAIT, 16'h0001, '0, '0, '1);
      send_request(REQ_REMOVE, 16'h0001, '0, 4'd0, '0);
      send_request(REQ_ADD, '0, '0, '0, '0);
      send_request(REQ_ADD, '1, '0, '0, '0);
      send_request(REQ_OWNED_ADD, 16'h0042, '0, '0, '0);
      send_request(REQ_OWNED_ADD, 16'h8000, '1, '0, '0);
      send_request(REQ_TYPE_W'(7), 16'h1111, '1, 4'd1, '1);
      send_request(REQ_WAIT, '0, '0, '0, '0);
      send_request(REQ_WAIT, '0, '0, '0, '1);
      send_request(REQ_REMOVE, '0, '0, 4'd15, '0);
      send_request(REQ_REMOVE, '0, '0, 4'd0, '0);
      // Fill to the top, then try both adds on a full table.
      while (tracker.count < SLOTS)
         send_request(REQ_ADD, EVENT_W'(16'h0100 + tracker.count), '0, '0, '0);
      send_request(REQ_ADD, 16'h7777, '0, '0, '0);
      send_request(REQ_OWNED_ADD, 16'h7777, '1, '0, '0);
      send_request(REQ_WAIT, '0, '0, '0, 16'h8000);
      send_request(REQ_REMOVE, '0, '0, 4'd15, '0);
      send_request(REQ_REMOVE, '0, '0, 4'd0, '0);
      send_request(REQ_CLEAR, '1, '1, '1, '1);

      // Ownership enforced: a zero id is rejected before the owner check.
      wait_for_replies();
      write_registers(POL_LOWEST, 32'h1234_5678, 1'b1);
      send_request(REQ_OWNED_ADD, 16'h00A5, 32'h8765_4321, '0, '0);
      send_request(REQ_OWNED_ADD, '0, 32'h8765_4321, '0, '0);
      send_request(REQ_OWNED_ADD, 16'h00A5, 32'h1234_5678, '0, '0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_replies();
         case (seg)
            1, 7:    owner_pick = '1;
            6:       owner_pick = '0;
            default: owner_pick = $urandom | 32'h1;
         endcase
         write_registers(2'(seg % 4), owner_pick, bit'((seg >> 1) & 1));
         phase = (seg + seg / 4) % 4;
         sender_idle_pct = (phase == 1) ? 75 : (phase == 3) ? 21 : 0;
         reply_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 21 : 0;
         repeat (SEGMENT_LEN) random_request();
      end

      wait_for_replies();
      if (tracker.errors == 0) begin
         $display("PASS event_slot_table_wake_select_top");
      end else begin
         $display("FAIL event_slot_table_wake_select_top");
      end
      $finish;
   end
endmodule
